// ----- rtl/tbf_pkg.sv -----
// ----------------------------------------------------------------------------
// tbf_pkg
// Shared types and constants of the throttled byte FIFO.
// ----------------------------------------------------------------------------
package tbf_pkg;

  localparam int FIFO_DEPTH = 512;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int FILL_W     = 10;
  localparam int CREDIT_W   = 8;
  localparam int BYTE_W     = 8;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_OFFER    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TX_READY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CREDITS_PER_TICK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_CREDITS      = 2'd1;

  localparam logic [CREDIT_W-1:0] CREDITS_PER_TICK_RST = 8'd2;
  localparam logic [CREDIT_W-1:0] MAX_CREDITS_RST      = 8'd16;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] data_in;
  } tbf_in_t;

  typedef struct packed {
    logic                accepted;
    logic                out_valid;
    logic [BYTE_W-1:0]   out_byte;
    logic [FILL_W-1:0]   fill_level;
    logic [CREDIT_W-1:0] credits_left;
  } tbf_out_t;

  typedef struct packed {
    logic              wr_en;
    logic [PTR_W-1:0]  wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [PTR_W-1:0]  rd_addr;
  } tbf_mem_req_t;

endpackage

// ----- rtl/tbf_mem.sv -----
// ----------------------------------------------------------------------------
// tbf_mem
// Byte store of the FIFO: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module tbf_mem (
  input  logic                  clk,
  input  tbf_pkg::tbf_mem_req_t req,
  output logic [tbf_pkg::BYTE_W-1:0] rd_data
);
  import tbf_pkg::*;

  logic [BYTE_W-1:0] store [FIFO_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      store[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= store[req.rd_addr];
    end
  end

endmodule

// ----- rtl/tbf_ctrl.sv -----
// ----------------------------------------------------------------------------
// tbf_ctrl
// Credit bucket, FIFO pointers and fill count. Decides each event and
// registers its result flags and levels.
// ----------------------------------------------------------------------------
module tbf_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           take,
  input  tbf_pkg::tbf_in_t               item,
  input  logic                           cfg_we,
  input  logic [tbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tbf_pkg::CREDIT_W-1:0]   cfg_data,
  output tbf_pkg::tbf_mem_req_t          mem_req,
  output logic                           accepted,
  output logic                           popped,
  output logic [tbf_pkg::FILL_W-1:0]     fill_level,
  output logic [tbf_pkg::CREDIT_W-1:0]   credits_left
);
  import tbf_pkg::*;

  logic [CREDIT_W-1:0] credits_per_tick;
  logic [CREDIT_W-1:0] max_credits;
  logic [PTR_W-1:0]    write_pointer, write_pointer_next;
  logic [PTR_W-1:0]    read_pointer, read_pointer_next;
  logic [CNT_W-1:0]    byte_count, byte_count_next;
  logic [CREDIT_W-1:0] credit_count, credit_count_next;
  logic [CREDIT_W:0]   credit_sum;
  logic                do_store, do_pop;

  always_comb begin
    credit_sum = {1'b0, credit_count} + {1'b0, credits_per_tick};
    do_store   = (item.command == CMD_OFFER) && (credit_count != '0) &&
                 (byte_count < CNT_W'(FIFO_DEPTH));
    do_pop     = (item.command == CMD_TX_READY) && (byte_count != '0);

    credit_count_next = credit_count;
    if (item.command == CMD_TICK) begin
      credit_count_next = (credit_sum < {1'b0, max_credits}) ?
                          credit_sum[CREDIT_W-1:0] : max_credits;
    end else if (do_store) begin
      credit_count_next = credit_count - 1'b1;
    end

    write_pointer_next = write_pointer;
    if (do_store) begin
      write_pointer_next = (write_pointer == PTR_W'(FIFO_DEPTH - 1)) ?
                           '0 : write_pointer + 1'b1;
    end
    read_pointer_next = read_pointer;
    if (do_pop) begin
      read_pointer_next = (read_pointer == PTR_W'(FIFO_DEPTH - 1)) ?
                          '0 : read_pointer + 1'b1;
    end

    byte_count_next = byte_count;
    if (do_store) begin
      byte_count_next = byte_count + 1'b1;
    end else if (do_pop) begin
      byte_count_next = byte_count - 1'b1;
    end

    mem_req.wr_en   = take && do_store;
    mem_req.wr_addr = write_pointer;
    mem_req.wr_data = item.data_in;
    mem_req.rd_en   = take && do_pop;
    mem_req.rd_addr = read_pointer;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credits_per_tick <= CREDITS_PER_TICK_RST;
      max_credits      <= MAX_CREDITS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CREDITS_PER_TICK: credits_per_tick <= cfg_data;
        REG_MAX_CREDITS:      max_credits      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
      byte_count    <= '0;
      credit_count  <= '0;
    end else if (take) begin
      write_pointer <= write_pointer_next;
      read_pointer  <= read_pointer_next;
      byte_count    <= byte_count_next;
      credit_count  <= credit_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      accepted     <= do_store;
      popped       <= do_pop;
      fill_level   <= FILL_W'(byte_count_next);
      credits_left <= credit_count_next;
    end
  end

endmodule

// ----- rtl/token_bucket_throttled_fifo.sv -----
// ----------------------------------------------------------------------------
// token_bucket_throttled_fifo
// Byte FIFO whose intake is limited by a token-bucket credit counter.
// ----------------------------------------------------------------------------
// Each input transfer is one event (tick, offered byte or transmitter ready)
// and yields exactly one result transfer, offered in the next cycle. An event can be
// taken every cycle; the block holds one result in its output register and
// takes a new event whenever that register is empty or being drained in the
// same cycle. The FIFO memory has one write and one registered read port, so
// a popped byte appears with the result of its event. Neither the event nor
// the configuration channel is ready while reset is held. Configuration
// writes are accepted in every cycle outside reset and are meant to arrive
// only while no event is pending.
module token_bucket_throttled_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tbf_pkg::tbf_in_t              in_data,
  output logic                          res_valid,
  input  logic                          res_ready,
  output tbf_pkg::tbf_out_t             res_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tbf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tbf_pkg::CREDIT_W-1:0]  cfg_data
);
  import tbf_pkg::*;

  tbf_mem_req_t        mem_req;
  logic [BYTE_W-1:0]   rd_data;
  logic                take;
  logic                accepted, popped;
  logic [FILL_W-1:0]   fill_level;
  logic [CREDIT_W-1:0] credits_left;

  assign in_ready  = !rst && (!res_valid || res_ready);
  assign take      = in_valid && in_ready;
  assign cfg_ready = !rst;

  tbf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .item         (in_data),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mem_req      (mem_req),
    .accepted     (accepted),
    .popped       (popped),
    .fill_level   (fill_level),
    .credits_left (credits_left)
  );

  tbf_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in_ready) begin
      res_valid <= in_valid;
    end
  end

  always_comb begin
    res_data.accepted     = accepted;
    res_data.out_valid    = popped;
    res_data.out_byte     = popped ? rd_data : '0;
    res_data.fill_level   = fill_level;
    res_data.credits_left = credits_left;
  end

endmodule

// ----- rtl/tbf_checker.sv -----
// ----------------------------------------------------------------------------
// tbf_checker
// Port-level checks of the throttled byte FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module tbf_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              res_valid,
  input logic              res_ready,
  input tbf_pkg::tbf_out_t res_data
);
  import tbf_pkg::*;

  // A stalled result must stay offered.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // Every input transfer is answered in the next cycle.
  a_res_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> res_valid)
    else $error("no result after an input transfer");

  a_one_action: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_data.accepted && res_data.out_valid))
    else $error("store and pop reported for one event");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.out_valid |-> res_data.out_byte == '0)
    else $error("byte shown without a pop");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.fill_level <= FILL_W'(FIFO_DEPTH))
    else $error("fill level beyond depth");

endmodule

bind token_bucket_throttled_fifo tbf_checker u_tbf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res_data  (res_data)
);
